// ===== rtl/salt_pkg.sv =====
// ----------------------------------------------------------------------------
// salt_pkg: shared types for the shifting array list table
// Operation and status codes, transaction payloads and the shift command
// that the control logic broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package salt_pkg;

   localparam int WORD_W   = 32;
   localparam int POS_W    = 8;
   localparam int LENGTH_W = 9;

   // operation codes, codes five to seven are ignored
   typedef enum logic [2:0] {
      OP_APPEND      = 3'd0,
      OP_INSERT      = 3'd1,
      OP_READ        = 3'd2,
      OP_DELETE      = 3'd3,
      OP_DELETE_LAST = 3'd4
   } salt_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } salt_status_type;

   typedef struct packed {
      logic [2:0]               op;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] data_in;
   } salt_req_type;

   typedef struct packed {
      salt_status_type          status;
      logic signed [WORD_W-1:0] data_out;
      logic [LENGTH_W-1:0]      length;
   } salt_rsp_type;

   // shift command seen by every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } salt_shift_type;

endpackage

// ===== rtl/salt_cell.sv =====
// ----------------------------------------------------------------------------
// salt_cell: one storage cell of the list
// Holds one word; on insert it writes the new word or takes its lower
// neighbor, on delete it takes its upper neighbor.
// ----------------------------------------------------------------------------
module salt_cell #(
   parameter int CW  = 9,
   parameter int IDX = 0
) (
   input  logic                         clock,
   input  salt_pkg::salt_shift_type     shift,
   input  logic [CW-1:0]                tpos,
   input  logic [CW-1:0]                count,
   input  logic [salt_pkg::WORD_W-1:0]  data_in,
   input  logic [salt_pkg::WORD_W-1:0]  left_word,
   input  logic [salt_pkg::WORD_W-1:0]  right_word,
   output logic [salt_pkg::WORD_W-1:0]  word,
   output logic [salt_pkg::WORD_W-1:0]  rd_word
);
   import salt_pkg::*;

   localparam logic [CW-1:0] MY_IDX = CW'(IDX);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   // next word from the shift command
   always_comb begin
      word_in = word_ff;
      if (shift.insert) begin
         if (MY_IDX == tpos) begin
            word_in = data_in;
         end else if ((MY_IDX > tpos) && (MY_IDX <= count)) begin
            word_in = left_word;
         end
      end else if (shift.remove) begin
         if (MY_IDX >= tpos) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // gated onto the read bus when addressed
   assign word    = word_ff;
   assign rd_word = (MY_IDX == tpos) ? word_ff : '0;

endmodule

// ===== rtl/salt_ctrl.sv =====
// ----------------------------------------------------------------------------
// salt_ctrl: operation decode and bounds checks
// Turns one request into a shift command, a target index, the next count
// and the status of the transaction.
// ----------------------------------------------------------------------------
module salt_ctrl #(
   parameter int CAPACITY = 256,
   parameter int CW       = 9
) (
   input  salt_pkg::salt_req_type       req,
   input  logic [CW-1:0]                count,
   output salt_pkg::salt_shift_type     shift,
   output logic [CW-1:0]                tpos,
   output logic [CW-1:0]                count_next,
   output salt_pkg::salt_status_type    status,
   output logic                         rd_en
);
   import salt_pkg::*;

   // compare width wide enough for both the index and the count
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CMPW-1:0] CAP_X = CMPW'(CAPACITY);

   logic [CMPW-1:0] cnt_x;
   logic [CMPW-1:0] pos_x;
   logic            full;
   logic [CW-1:0]   pos_c;

   assign cnt_x = CMPW'(count);
   assign pos_x = CMPW'(req.position);
   assign full  = (cnt_x >= CAP_X);
   assign pos_c = CW'(pos_x);

   // decode and range checks
   always_comb begin
      shift      = '0;
      tpos       = pos_c;
      count_next = count;
      status     = ST_OK;
      rd_en      = 1'b0;
      unique case (req.op)
         OP_APPEND: begin
            tpos = count;
            if (full) begin
               status = ST_FULL;
            end else begin
               shift.insert = 1'b1;
               count_next   = count + CW'(1);
            end
         end
         OP_INSERT: begin
            if (pos_x > cnt_x) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               shift.insert = 1'b1;
               count_next   = count + CW'(1);
            end
         end
         OP_READ: begin
            if (pos_x >= cnt_x) begin
               status = ST_RANGE;
            end else begin
               rd_en = 1'b1;
            end
         end
         OP_DELETE: begin
            if (pos_x >= cnt_x) begin
               status = ST_RANGE;
            end else begin
               shift.remove = 1'b1;
               count_next   = count - CW'(1);
            end
         end
         OP_DELETE_LAST: begin
            if (count == '0) begin
               status = ST_EMPTY;
            end else begin
               count_next = count - CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/shifting_array_list_table_unit.sv =====
// ----------------------------------------------------------------------------
// shifting_array_list_table_unit: ordered list of words with shifting
// insert and delete, kept in a row of cells that move data to neighbors.
// ----------------------------------------------------------------------------
// response: registered, valid in the cycle after the request is accepted
// throughput: one transaction per cycle unless the response stalls; every
// cell shifts with its neighbor in parallel for a whole insert or delete
// reset: synchronous, clears the count and the response valid; the cell
// words are not cleared and are only read below the count
module shifting_array_list_table_unit #(
   parameter int CAPACITY = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  salt_pkg::salt_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output salt_pkg::salt_rsp_type rsp_payload
);
   import salt_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int LEXT = (CW > LENGTH_W) ? CW : LENGTH_W;

   logic                 accept;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   salt_rsp_type         rsp_ff;
   salt_rsp_type         rsp_in;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;

   salt_shift_type       shift;
   salt_shift_type       shift_gated;
   logic [CW-1:0]        tpos;
   salt_status_type      status;
   logic                 rd_en;
   logic [WORD_W-1:0]    rd_bus;
   logic [LEXT-1:0]      len_ext;

   logic [WORD_W-1:0]    words    [CAPACITY];
   logic [WORD_W-1:0]    rd_words [CAPACITY];

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   salt_ctrl #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_ctrl (
      .req        (req_payload),
      .count      (count_ff),
      .shift      (shift),
      .tpos       (tpos),
      .count_next (count_in),
      .status     (status),
      .rd_en      (rd_en)
   );

   assign shift_gated = accept ? shift : '0;

   // row of storage cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] left_w;
      logic [WORD_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = words[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = words[i];
      end else begin : g_right
         assign right_w = words[i+1];
      end
      salt_cell #(
         .CW  (CW),
         .IDX (i)
      ) u_cell (
         .clock      (clock),
         .shift      (shift_gated),
         .tpos       (tpos),
         .count      (count_ff),
         .data_in    (req_payload.data_in),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (words[i]),
         .rd_word    (rd_words[i])
      );
   end

   // read bus, only the addressed cell drives a nonzero word
   always_comb begin
      rd_bus = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_bus = rd_bus | rd_words[i];
      end
   end

   // response assembly
   assign len_ext = LEXT'(count_in);
   always_comb begin
      rsp_in.status   = status;
      rsp_in.data_out = rd_en ? rd_bus : '0;
      rsp_in.length   = len_ext[LENGTH_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
